FILE: src/pcpa_pkg.sv
// Shared types and constants for the pulse count position averager.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package pcpa_pkg;

    // Pairs per row before the row is closed regardless of position
    localparam int ROW_PAIRS = 65536;

    // Field widths
    localparam int POS_W  = 32;
    localparam int DATA_W = 16;
    localparam int VAL_W  = 16;

    // Pair counter and accumulator widths follow from the row length
    localparam int PAIR_W = $clog2(ROW_PAIRS + 1);
    localparam int SUM_W  = DATA_W + PAIR_W;

    // Divider iteration counter
    localparam int STEP_W = $clog2(SUM_W);

    // Stream payload widths
    localparam int IN_W   = 160;
    localparam int OUT_W  = 112;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_THRESHOLD = 1'b1;
    localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 16'sd2500;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One pending result: a raw sample is carried as a sum with count one
    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic signed [POS_W-1:0]  out_y;
        logic signed [POS_W-1:0]  out_z;
        logic signed [SUM_W-1:0]  sum;
        logic        [PAIR_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

FILE: src/pcpa_front.sv
// Front end: configuration registers, row state, pulse edge stepping and accumulation.
// Pushes one job per result into the queue. Depends on pcpa_pkg.
`timescale 1ns / 1ps

module pcpa_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcpa_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // start_pos, end_pos, row_y, row_z, data_sample, pulse_sample
    input  logic [pcpa_pkg::IN_W-1:0]             s_tdata,
    // first_of_row
    input  logic [0:0]                            s_tuser,
    input  pcpa_pkg::queue_status_t               q_status,
    output logic                                  q_push,
    output pcpa_pkg::job_t                        q_job
);

    logic                                  filter_enable_reg;
    logic signed [pcpa_pkg::DATA_W-1:0]    pulse_threshold_reg;

    logic                                  row_active_reg, row_active_next;
    logic signed [pcpa_pkg::POS_W-1:0]     cur_pos_reg, cur_pos_next;
    logic signed [pcpa_pkg::POS_W-1:0]     target_reg, target_next;
    logic                                  moving_back_reg, moving_back_next;
    logic                                  edge_armed_reg, edge_armed_next;
    logic                                  first_pending_reg, first_pending_next;
    logic signed [pcpa_pkg::SUM_W-1:0]     avg_sum_reg, avg_sum_next;
    logic        [pcpa_pkg::PAIR_W-1:0]    avg_count_reg, avg_count_next;
    logic        [pcpa_pkg::PAIR_W-1:0]    pair_count_reg, pair_count_next;
    logic signed [pcpa_pkg::POS_W-1:0]     last_pos_reg, last_pos_next;
    logic signed [pcpa_pkg::POS_W-1:0]     held_y_reg, held_y_next;
    logic signed [pcpa_pkg::POS_W-1:0]     held_z_reg, held_z_next;

    logic                                  load;
    logic signed [pcpa_pkg::POS_W-1:0]     start_pos, end_pos, row_y, row_z;
    logic signed [pcpa_pkg::DATA_W-1:0]    data_sample, pulse_sample;
    logic signed [pcpa_pkg::SUM_W-1:0]     data_ext;
    logic signed [pcpa_pkg::POS_W-1:0]     pos0, pos1;
    logic signed [pcpa_pkg::SUM_W-1:0]     sum0, sum1;
    logic        [pcpa_pkg::PAIR_W-1:0]    cnt0, cnt1, pc0, pc1;
    logic                                  back0, armed0, fp0, act0;
    logic                                  pulse_on, step;
    logic                                  accept, emit;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && emit;

    // Unpack the input word
    assign load         = s_tuser[0];
    assign start_pos    = s_tdata[31:0];
    assign end_pos      = s_tdata[63:32];
    assign row_y        = s_tdata[95:64];
    assign row_z        = s_tdata[127:96];
    assign data_sample  = s_tdata[143:128];
    assign pulse_sample = s_tdata[159:144];
    assign data_ext     = {{(pcpa_pkg::SUM_W - pcpa_pkg::DATA_W){data_sample[pcpa_pkg::DATA_W-1]}},
                           data_sample};

    // Load row fields, step on a pulse edge, accumulate and decide on a result
    always_comb begin
        pos0   = load ? start_pos : cur_pos_reg;
        back0  = load ? (start_pos > end_pos) : moving_back_reg;
        armed0 = load ? 1'b1 : edge_armed_reg;
        fp0    = load ? 1'b1 : first_pending_reg;
        act0   = load ? (start_pos != end_pos) : row_active_reg;
        sum0   = load ? '0 : avg_sum_reg;
        cnt0   = load ? '0 : avg_count_reg;
        pc0    = load ? '0 : pair_count_reg;

        pulse_on = pulse_sample < pulse_threshold_reg;
        step     = pulse_on && armed0;
        if (step) begin
            pos1 = back0 ? (pos0 - 32'sd1) : (pos0 + 32'sd1);
        end else begin
            pos1 = pos0;
        end
        sum1 = sum0 + data_ext;
        cnt1 = cnt0 + pcpa_pkg::PAIR_W'(1);
        pc1  = pc0 + pcpa_pkg::PAIR_W'(1);

        row_active_next    = act0;
        cur_pos_next       = pos0;
        target_next        = load ? end_pos : target_reg;
        moving_back_next   = back0;
        edge_armed_next    = armed0;
        first_pending_next = fp0;
        avg_sum_next       = sum0;
        avg_count_next     = cnt0;
        pair_count_next    = pc0;
        last_pos_next      = last_pos_reg;
        held_y_next        = load ? row_y : held_y_reg;
        held_z_next        = load ? row_z : held_z_reg;

        emit           = 1'b0;
        q_job.position = pos1;
        q_job.out_y    = held_y_next;
        q_job.out_z    = held_z_next;
        q_job.sum      = data_ext;
        q_job.count    = pcpa_pkg::PAIR_W'(1);

        if (act0) begin
            cur_pos_next    = pos1;
            edge_armed_next = !pulse_on;
            pair_count_next = pc1;
            row_active_next = !((pos1 == target_next) ||
                                (pc1 >= pcpa_pkg::PAIR_W'(pcpa_pkg::ROW_PAIRS)));
            if (!filter_enable_reg) begin
                emit = 1'b1;
            end else begin
                avg_sum_next   = sum1;
                avg_count_next = cnt1;
                if (fp0 || (last_pos_reg != pos1)) begin
                    emit               = 1'b1;
                    q_job.sum          = sum1;
                    q_job.count        = cnt1;
                    avg_sum_next       = '0;
                    avg_count_next     = '0;
                    last_pos_next      = pos1;
                    first_pending_next = 1'b0;
                end
            end
        end
    end

    // Hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_enable_reg   <= 1'b0;
            pulse_threshold_reg <= pcpa_pkg::THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pcpa_pkg::CFG_FILTER_ENABLE:   filter_enable_reg   <= cfg_wdata[0];
                pcpa_pkg::CFG_PULSE_THRESHOLD: pulse_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance row state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_active_reg    <= 1'b0;
            cur_pos_reg       <= '0;
            target_reg        <= '0;
            moving_back_reg   <= 1'b0;
            edge_armed_reg    <= 1'b1;
            first_pending_reg <= 1'b0;
            avg_sum_reg       <= '0;
            avg_count_reg     <= '0;
            pair_count_reg    <= '0;
            last_pos_reg      <= '0;
            held_y_reg        <= '0;
            held_z_reg        <= '0;
        end else if (accept) begin
            row_active_reg    <= row_active_next;
            cur_pos_reg       <= cur_pos_next;
            target_reg        <= target_next;
            moving_back_reg   <= moving_back_next;
            edge_armed_reg    <= edge_armed_next;
            first_pending_reg <= first_pending_next;
            avg_sum_reg       <= avg_sum_next;
            avg_count_reg     <= avg_count_next;
            pair_count_reg    <= pair_count_next;
            last_pos_reg      <= last_pos_next;
            held_y_reg        <= held_y_next;
            held_z_reg        <= held_z_next;
        end
    end

endmodule

FILE: src/pcpa_queue.sv
// Small job queue that decouples the front end from the result stage.
// Register array with read and write pointers. Depends on pcpa_pkg.
`timescale 1ns / 1ps

module pcpa_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  pcpa_pkg::job_t           wr_job,
    input  logic                     pop,
    output pcpa_pkg::job_t           rd_job,
    output pcpa_pkg::queue_status_t  status
);

    pcpa_pkg::job_t                  slots [pcpa_pkg::QUEUE_DEPTH];
    logic [pcpa_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [pcpa_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [pcpa_pkg::QCNT_W-1:0]     count_reg;

    assign rd_job       = slots[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == pcpa_pkg::QCNT_W'(pcpa_pkg::QUEUE_DEPTH));

    // Store a pushed job
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= wr_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + pcpa_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + pcpa_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + pcpa_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - pcpa_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

FILE: src/pcpa_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Divides the accumulated sum by the sample count. Depends on pcpa_pkg.
`timescale 1ns / 1ps

module pcpa_divider (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [pcpa_pkg::SUM_W-1:0]    dividend,
    input  logic        [pcpa_pkg::PAIR_W-1:0]   divisor,
    output logic                                 done,
    output logic signed [pcpa_pkg::VAL_W-1:0]    quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic                               neg_reg;
    logic [pcpa_pkg::SUM_W-1:0]         quo_reg;
    logic [pcpa_pkg::PAIR_W-1:0]        rem_reg;
    logic [pcpa_pkg::PAIR_W-1:0]        den_reg;
    logic [pcpa_pkg::STEP_W-1:0]        step_reg;

    logic [pcpa_pkg::SUM_W-1:0]         magnitude;
    logic [pcpa_pkg::PAIR_W:0]          rem_sh;
    logic [pcpa_pkg::PAIR_W:0]          diff;
    logic                               fits;
    logic [pcpa_pkg::PAIR_W-1:0]        rem_new;
    logic [pcpa_pkg::SUM_W-1:0]         quo_signed;

    assign magnitude = dividend[pcpa_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;

    // Shift in one dividend bit and try a subtract
    assign rem_sh  = {rem_reg, quo_reg[pcpa_pkg::SUM_W-1]};
    assign diff    = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});
    assign rem_new = fits ? diff[pcpa_pkg::PAIR_W-1:0] : rem_sh[pcpa_pkg::PAIR_W-1:0];

    // Restore the sign and keep the low bits
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[pcpa_pkg::VAL_W-1:0];
    assign done       = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                quo_reg  <= magnitude;
                rem_reg  <= '0;
                den_reg  <= divisor;
                neg_reg  <= dividend[pcpa_pkg::SUM_W-1];
                step_reg <= pcpa_pkg::STEP_W'(pcpa_pkg::SUM_W - 1);
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[pcpa_pkg::SUM_W-2:0], fits};
                rem_reg <= rem_new;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - pcpa_pkg::STEP_W'(1);
                end
            end
        end
    end

endmodule

FILE: src/pcpa_back.sv
// Result stage: pops jobs, divides averages, and holds the output word.
// Instantiates pcpa_divider. Depends on pcpa_pkg.
`timescale 1ns / 1ps

module pcpa_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pcpa_pkg::queue_status_t            q_status,
    input  pcpa_pkg::job_t                     q_job,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // position, out_y, out_z, value
    output logic [pcpa_pkg::OUT_W-1:0]         m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } back_state_t;

    back_state_t                          state_reg;
    logic signed [pcpa_pkg::POS_W-1:0]    pos_reg;
    logic signed [pcpa_pkg::POS_W-1:0]    y_reg;
    logic signed [pcpa_pkg::POS_W-1:0]    z_reg;
    logic signed [pcpa_pkg::VAL_W-1:0]    value_reg;

    logic                                 take;
    logic                                 single;
    logic                                 div_start;
    logic                                 div_done;
    logic signed [pcpa_pkg::VAL_W-1:0]    div_quot;

    // Take a new job when idle or when the held word leaves
    assign take      = (state_reg == S_IDLE) || ((state_reg == S_OUT) && m_tready);
    assign q_pop     = take && !q_status.empty;
    assign single    = (q_job.count == pcpa_pkg::PAIR_W'(1));
    assign div_start = q_pop && !single;

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {value_reg, z_reg, y_reg, pos_reg};

    pcpa_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (q_job.sum),
        .divisor  (q_job.count),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequence jobs and hold the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE, S_OUT: begin
                    if (take) begin
                        if (!q_status.empty) begin
                            pos_reg <= q_job.position;
                            y_reg   <= q_job.out_y;
                            z_reg   <= q_job.out_z;
                            if (single) begin
                                value_reg <= q_job.sum[pcpa_pkg::VAL_W-1:0];
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        value_reg <= div_quot;
                        state_reg <= S_OUT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/pulse_count_position_averager.sv
// Pulse count position averager, top level: front end, job queue and result stage.
// Raw words go through a queue slot and the output register, one word per cycle
// sustained while m_tready stays high. Averages: no job is popped during a division;
// the front end still takes a pair per cycle until the 4-entry queue fills.
// Synchronous active-low reset clears row state, queue and output valid;
// filter_enable resets to 0 and pulse_threshold to 2500.
`timescale 1ns / 1ps

module pulse_count_position_averager (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_pos, end_pos, row_y, row_z, data_sample, pulse_sample
    input  logic [pcpa_pkg::IN_W-1:0]          s_tdata,
    // first_of_row
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // position, out_y, out_z, value
    output logic [pcpa_pkg::OUT_W-1:0]         m_tdata
);

    pcpa_pkg::queue_status_t  q_status;
    pcpa_pkg::job_t           push_job;
    pcpa_pkg::job_t           pop_job;
    logic                     q_push;
    logic                     q_pop;

    pcpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    pcpa_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_job  (push_job),
        .pop     (q_pop),
        .rd_job  (pop_job),
        .status  (q_status)
    );

    pcpa_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("job pushed into full queue");

    // Result stage never pops an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    // A job pushed into an empty queue is visible next cycle
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop && q_status.empty) |=> !q_status.empty)
        else $error("pushed job lost");

endmodule

FILE: test/pulse_count_position_averager_tb.sv
// Testbench for pulse_count_position_averager: directed and random scan rows in raw and
// filter mode, checked word by word against a scan predictor kept in step with the input.
// Depends on pcpa_pkg and the block's RTL only.
`timescale 1ns / 1ps

module pulse_count_position_averager_tb;

    // One sample pair as it travels on the input stream, tuser bit on top
    typedef struct packed {
        logic               first_of_row;
        logic signed [15:0] pulse_sample;
        logic signed [15:0] data_sample;
        logic signed [31:0] row_z;
        logic signed [31:0] row_y;
        logic signed [31:0] end_pos;
        logic signed [31:0] start_pos;
    } scan_pair_t;

    // One output word, position in the lowest bits
    typedef struct packed {
        logic signed [15:0] value;
        logic signed [31:0] out_z;
        logic signed [31:0] out_y;
        logic signed [31:0] position;
    } scan_point_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_STALL,
        RX_MOSTLY
    } rx_pattern_t;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 64;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [pcpa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pcpa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [pcpa_pkg::IN_W-1:0]       s_tdata   = '0;
    logic [0:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [pcpa_pkg::OUT_W-1:0]      m_tdata;

    pulse_count_position_averager u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and expectations
    scan_pair_t  pair_queue[$];
    scan_point_t expected_points[$];
    int          generated   = 0;
    int          error_count = 0;

    // Scan predictor state
    bit                 model_filter_on = 1'b0;
    logic signed [15:0] model_threshold = pcpa_pkg::THRESHOLD_RESET;
    bit                 row_open    = 1'b0;
    logic [31:0]        step_pos    = '0;
    logic [31:0]        stop_pos    = '0;
    bit                 count_down  = 1'b0;
    bit                 edge_ready  = 1'b1;
    bit                 first_due   = 1'b0;
    longint             sample_sum  = 0;
    int                 sample_cnt  = 0;
    logic [31:0]        emitted_pos = '0;
    logic [31:0]        row_y_held  = '0;
    logic [31:0]        row_z_held  = '0;
    int                 row_pairs   = 0;

    // Driver and receiver state
    bit          s_took_word = 1'b0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    scan_pair_t  next_pair;
    bit          long_hold_req = 1'b0;
    int          hold_count    = 0;
    int          rx_run_left   = 0;
    rx_pattern_t rx_mode       = RX_STREAM;

    // Step the scan state for one accepted pair and queue the word it produces
    task automatic advance_scan(input scan_pair_t p);
        logic signed [15:0] avg;
        bit                 emit;
        avg  = '0;
        emit = 1'b0;
        if (p.first_of_row) begin
            step_pos   = p.start_pos;
            stop_pos   = p.end_pos;
            count_down = $signed(p.start_pos) > $signed(p.end_pos);
            row_y_held = p.row_y;
            row_z_held = p.row_z;
            edge_ready = 1'b1;
            first_due  = 1'b1;
            sample_sum = 0;
            sample_cnt = 0;
            row_pairs  = 0;
            row_open   = (p.start_pos != p.end_pos);
        end
        if (!row_open)
            return;
        // One step per falling edge through the threshold
        if ($signed(p.pulse_sample) < $signed(model_threshold)) begin
            if (edge_ready) begin
                edge_ready = 1'b0;
                step_pos   = count_down ? step_pos - 32'd1 : step_pos + 32'd1;
            end
        end else begin
            edge_ready = 1'b1;
        end
        if (!model_filter_on) begin
            emit = 1'b1;
            avg  = p.data_sample;
        end else begin
            sample_sum += $signed(p.data_sample);
            sample_cnt++;
            if (first_due || emitted_pos != step_pos) begin
                emit        = 1'b1;
                avg         = 16'(sample_sum / sample_cnt);
                sample_sum  = 0;
                sample_cnt  = 0;
                emitted_pos = step_pos;
                first_due   = 1'b0;
            end
        end
        row_pairs++;
        if (step_pos == stop_pos || row_pairs >= pcpa_pkg::ROW_PAIRS)
            row_open = 1'b0;
        if (emit)
            expected_points.push_back('{value: avg, out_z: row_z_held, out_y: row_y_held,
                                        position: step_pos});
    endtask

    function automatic int check_field(input string name, input logic signed [31:0] exp_v,
                                       input logic signed [31:0] act_v);
        if (exp_v === act_v)
            return 0;
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        return 1;
    endfunction

    // Predict on accepted input words, check accepted output words
    always @(posedge aclk) begin
        scan_point_t exp_p;
        scan_point_t got_p;
        if (!aresetn) begin
            s_took_word <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == pcpa_pkg::CFG_FILTER_ENABLE)
                    model_filter_on = cfg_wdata[0];
                else if (cfg_index == pcpa_pkg::CFG_PULSE_THRESHOLD)
                    model_threshold = cfg_wdata;
            end
            s_took_word <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                advance_scan(scan_pair_t'({s_tuser, s_tdata}));
            if (m_tvalid && m_tready) begin
                got_p = scan_point_t'(m_tdata);
                if (expected_points.size() == 0) begin
                    $error("unexpected output word: position %0d value %0d",
                           got_p.position, got_p.value);
                    error_count++;
                end else begin
                    exp_p = expected_points.pop_front();
                    error_count += check_field("position", exp_p.position, got_p.position);
                    error_count += check_field("out_y", exp_p.out_y, got_p.out_y);
                    error_count += check_field("out_z", exp_p.out_z, got_p.out_z);
                    error_count += check_field("value", 32'(exp_p.value), 32'(got_p.value));
                end
            end
        end
    end

    // Sender: bursts of words from the pending queue, random gaps between bursts
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_took_word)) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pair_queue.size() > 0) begin
                next_pair = pair_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_pair.first_of_row;
                s_tdata  <= next_pair[pcpa_pkg::IN_W-1:0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off on request, otherwise runs of random stall patterns
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && hold_count < LONG_HOLD_CYCLES) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            if (rx_run_left == 0) begin
                rx_run_left <= $urandom_range(1, 40);
                rx_mode     <= rx_pattern_t'($urandom_range(0, 3));
            end else begin
                rx_run_left <= rx_run_left - 1;
            end
            case (rx_mode)
                RX_STREAM: m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_STALL:  m_tready <= 1'b0;
                default:   m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic push_pair(input bit first, input logic signed [31:0] start_p,
                             input logic signed [31:0] end_p, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [15:0] data,
                             input logic signed [15:0] pulse);
        pair_queue.push_back('{first_of_row: first, pulse_sample: pulse, data_sample: data,
                               row_z: z, row_y: y, end_pos: end_p, start_pos: start_p});
        generated++;
    endtask

    // Pulse sample on the wanted side of the current threshold, sometimes anything
    function automatic logic signed [15:0] pulse_level(input bit want_high);
        int thr;
        thr = model_threshold;
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        if (want_high || thr == -32768)
            return 16'(thr + $urandom_range(0, 32767 - thr));
        return 16'(thr - 1 - $urandom_range(0, thr + 32767));
    endfunction

    // Pair with random content in every field the block ignores
    task automatic push_follow(input logic signed [15:0] pulse);
        push_pair(1'b0, $urandom, $urandom, $urandom, $urandom, 16'($urandom), pulse);
    endtask

    // Well-formed row: start pair, a high/low run per step, up to two pairs past the end
    task automatic add_scan_row();
        logic signed [31:0] start_p;
        logic signed [31:0] end_p;
        int                 span;
        int                 run;
        int                 i;
        int                 k;
        case ($urandom_range(0, 3))
            0:       start_p = $urandom;
            1:       start_p = 32'sh7FFFFFFF - $urandom_range(0, 4);
            2:       start_p = 32'sh80000000 + $urandom_range(0, 4);
            default: start_p = $signed($urandom_range(0, 16)) - 8;
        endcase
        span  = $urandom_range(1, 5);
        end_p = $urandom_range(0, 1) ? start_p - span : start_p + span;
        push_pair(1'b1, start_p, end_p, $urandom, $urandom, 16'($urandom),
                  pulse_level($urandom_range(0, 1)));
        for (i = 0; i < span; i++) begin
            run = $urandom_range(1, 3);
            for (k = 0; k < run; k++)
                push_follow(pulse_level(1'b1));
            run = $urandom_range(1, 3);
            for (k = 0; k < run; k++)
                push_follow(pulse_level(1'b0));
            // abandon the row now and then
            if ($urandom_range(0, 15) == 0)
                return;
        end
        run = $urandom_range(0, 2);
        for (k = 0; k < run; k++)
            push_follow(16'($urandom));
    endtask

    // Noise: stray pairs, empty rows, rows with far-apart random ends
    task automatic add_noise();
        logic signed [31:0] pos;
        int                 k;
        pos = $urandom;
        case ($urandom_range(0, 2))
            0: push_follow(16'($urandom));
            1: begin
                push_pair(1'b1, pos, pos, $urandom, $urandom, 16'($urandom), 16'($urandom));
                push_follow(16'($urandom));
            end
            default: begin
                push_pair(1'b1, pos, $urandom, $urandom, $urandom, 16'($urandom),
                          16'($urandom));
                for (k = 0; k < 4; k++)
                    push_follow(16'($urandom));
            end
        endcase
    endtask

    task automatic wait_drained();
        while (pair_queue.size() != 0 || s_tvalid || expected_points.size() != 0)
            @(posedge aclk);
        // let the block settle before touching configuration
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input bit filter_on, input logic signed [15:0] thr);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= pcpa_pkg::CFG_FILTER_ENABLE;
        cfg_wdata <= pcpa_pkg::CFG_DATA_W'(filter_on);
        @(negedge aclk);
        cfg_index <= pcpa_pkg::CFG_PULSE_THRESHOLD;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input bit filter_on, input logic signed [15:0] thr,
                             input int count, input bit hold);
        int target;
        set_mode(filter_on, thr);
        if (hold)
            long_hold_req = 1'b1;
        target = generated + count;
        while (generated < target) begin
            if ($urandom_range(0, 9) == 0)
                add_noise();
            else
                add_scan_row();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Raw mode at reset settings: no row, empty row, forward row through zero
        push_pair(1'b0, 0, 0, 0, 0, 16'sh1234, 3000);
        push_pair(1'b1, 5, 5, 1, 2, 7, 3000);
        push_pair(1'b0, 0, 0, 0, 0, 9, 0);
        push_pair(1'b1, -2, 1, 32'sh7FFFFFFF, 32'sh80000000, 32767, 3000);
        push_pair(1'b0, 0, 0, 0, 0, -32768, 2499);
        push_pair(1'b0, 0, 0, 0, 0, 0, 2499);
        push_pair(1'b0, 0, 0, 0, 0, 1, 32767);
        push_pair(1'b0, 0, 0, 0, 0, -1, -32768);
        push_pair(1'b0, 0, 0, 0, 0, 2, 2500);
        push_pair(1'b0, 0, 0, 0, 0, 3, 2499);
        // past the end of the row
        push_pair(1'b0, 0, 0, 0, 0, 4, 0);
        // backward row stepping on its first pair
        push_pair(1'b1, 1, -1, -1, 0, 5, 0);
        push_pair(1'b0, 0, 0, 0, 0, 6, 2500);
        push_pair(1'b0, 0, 0, 0, 0, 7, 2499);
        // new row, then an empty row abandoning it mid row
        push_pair(1'b1, 10, 20, 3, 4, 8, 3000);
        push_pair(1'b1, 3, 3, 5, 6, 9, 3000);
        push_pair(1'b0, 0, 0, 0, 0, 10, 0);

        // Filter mode: first-pair average, truncation toward zero, dropped sum
        set_mode(1'b1, pcpa_pkg::THRESHOLD_RESET);
        push_pair(1'b1, 0, 2, 11, 12, 32767, 3000);
        push_pair(1'b0, 0, 0, 0, 0, 32767, 3000);
        push_pair(1'b0, 0, 0, 0, 0, -32768, 0);
        push_pair(1'b0, 0, 0, 0, 0, -3, 3000);
        push_pair(1'b0, 0, 0, 0, 0, -2, 0);
        push_pair(1'b1, 0, 5, 13, 14, 100, 3000);
        push_pair(1'b0, 0, 0, 0, 0, 50, 3000);
        push_pair(1'b1, 5, 4, 15, 16, -7, 0);

        // Random rows across threshold extremes and both modes
        run_phase(1'b0, -32768, 100, 1'b0);
        run_phase(1'b1, 32767, 120, 1'b0);
        run_phase(1'b0, 16'($signed($urandom_range(0, 8000)) - 4000), 220, 1'b1);
        run_phase(1'b1, 16'($signed($urandom_range(0, 8000)) - 4000), 200, 1'b0);
        run_phase(1'b0, 0, 130, 1'b0);
        run_phase(1'b1, -100, 130, 1'b0);

        wait_drained();
        if (error_count == 0)
            $display("pulse_count_position_averager test passed");
        else
            $display("pulse_count_position_averager test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("pulse_count_position_averager test failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/pcpa_pkg.sv
src/pcpa_front.sv
src/pcpa_queue.sv
src/pcpa_divider.sv
src/pcpa_back.sv
src/pulse_count_position_averager.sv
test/pulse_count_position_averager_tb.sv
